// File: rtl/pfdr_pkg.sv
package pfdr_pkg;

    localparam logic [7:0] CMD_CTRL     = 8'h00;
    localparam logic [7:0] DATA_CTRL    = 8'h40;
    localparam logic [7:0] PAGE_CMD     = 8'hB0;
    localparam logic [7:0] COL_LOW_CMD  = 8'h00;
    localparam logic [7:0] COL_HIGH_CMD = 8'h10;

    typedef enum logic [1:0] {
        REQ_DRAW,
        REQ_FILL,
        REQ_CLEAR,
        REQ_REFRESH
    } req_kind_t;

    typedef enum logic [1:0] {
        CMD_PAGE,
        CMD_COL_LO,
        CMD_COL_HI
    } cmd_step_t;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_CMD,
        ST_DAT_RD,
        ST_DAT_CAP
    } state_t;

    typedef struct packed {
        req_kind_t   req_type;
        logic [7:0]  x_first;
        logic [7:0]  y_first;
        logic [7:0]  x_last;
        logic [7:0]  y_last;
        logic        dot_on;
        logic [2:0]  page_index;
    } req_t;

    typedef struct packed {
        logic [7:0]  control_byte;
        logic [63:0] payload;
        logic [3:0]  byte_count;
        logic        transfer_start;
        logic        last;
    } res_t;

endpackage

// File: rtl/pfdr_store.sv
module pfdr_store
    import pfdr_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/page_framebuffer_draw_refresh_top.sv
// draw point and fill: each touched column byte is read, then written back, on one shared read-modify-write path
// clear: wipes all COLUMNS << PB store bytes, PB = max(1, ceil(log2(PAGES))), one store write per cycle
// refresh: 3 command items, then each column byte is read and captured through the single read port
// results come out one per strobe cycle and the receiver cannot stall; busy while working
// after reset all COLUMNS << PB store bytes are wiped with busy high
module page_framebuffer_draw_refresh_top
    import pfdr_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic strobe,
    output res_t result
);

    localparam int CB    = $clog2(COLUMNS);
    localparam int PB    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = CB + PB;
    localparam int DEPTH = COLUMNS << PB;
    localparam int ROWS  = PAGES * 8;

    localparam logic [7:0]    X_MAX     = 8'(COLUMNS - 1);
    localparam logic [7:0]    Y_MAX     = 8'(ROWS - 1);
    localparam logic [CB-1:0] LAST_COL  = CB'(COLUMNS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [4:0]    PAGE_LIM  = 5'(PAGES);

    state_t        state_reg, state_next;
    logic [AW-1:0] wipe_addr_reg, wipe_addr_next;
    cmd_step_t     cmd_reg, cmd_next;
    logic          strobe_reg, strobe_next;

    logic [CB-1:0] col_reg, col_next;
    logic [CB-1:0] col_first_reg, col_first_next;
    logic [CB-1:0] col_last_reg, col_last_next;
    logic [PB-1:0] page_reg, page_next;
    logic [PB-1:0] page_first_reg, page_first_next;
    logic [PB-1:0] page_last_reg, page_last_next;
    logic [2:0]    bit_lo_reg, bit_lo_next;
    logic [2:0]    bit_hi_reg, bit_hi_next;
    logic          dot_reg, dot_next;
    logic [2:0]    byte_idx_reg, byte_idx_next;
    logic          first_chunk_reg, first_chunk_next;
    logic [63:0]   acc_reg, acc_next;
    res_t          res_reg, res_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    logic [7:0]    xl_eff, yl_eff, xl_clamp, yl_clamp;
    logic [7:0]    mask;
    logic [63:0]   acc_word;

    pfdr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // a point is a one-pixel rectangle
    always_comb
    begin
        xl_eff   = (req.req_type == REQ_DRAW) ? req.x_first : req.x_last;
        yl_eff   = (req.req_type == REQ_DRAW) ? req.y_first : req.y_last;
        xl_clamp = (xl_eff > X_MAX) ? X_MAX : xl_eff;
        yl_clamp = (yl_eff > Y_MAX) ? Y_MAX : yl_eff;
    end

    // bits of the current byte that lie inside the row span
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            mask[b] = ((page_reg != page_first_reg) || (3'(b) >= bit_lo_reg)) &&
                      ((page_reg != page_last_reg) || (3'(b) <= bit_hi_reg));
        end
    end

    always_comb
    begin
        acc_word = acc_reg;
        acc_word[8*byte_idx_reg +: 8] = rdata;
    end

    always_comb
    begin
        state_next       = state_reg;
        wipe_addr_next   = wipe_addr_reg;
        cmd_next         = cmd_reg;
        strobe_next      = 1'b0;
        col_next         = col_reg;
        col_first_next   = col_first_reg;
        col_last_next    = col_last_reg;
        page_next        = page_reg;
        page_first_next  = page_first_reg;
        page_last_next   = page_last_reg;
        bit_lo_next      = bit_lo_reg;
        bit_hi_next      = bit_hi_reg;
        dot_next         = dot_reg;
        byte_idx_next    = byte_idx_reg;
        first_chunk_next = first_chunk_reg;
        acc_next         = acc_reg;
        res_next         = res_reg;
        we               = 1'b0;
        waddr            = {col_reg, page_reg};
        wdata            = dot_reg ? (rdata | mask) : (rdata & ~mask);
        raddr            = {col_reg, page_reg};

        unique case (state_reg)
            ST_WIPE:
            begin
                we    = 1'b1;
                waddr = wipe_addr_reg;
                wdata = 8'h00;
                wipe_addr_next = wipe_addr_reg + AW'(1);
                if (wipe_addr_reg == LAST_ADDR)
                begin
                    wipe_addr_next = '0;
                    state_next     = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req.req_type)
                        REQ_DRAW, REQ_FILL:
                        begin
                            col_next        = req.x_first[CB-1:0];
                            col_first_next  = req.x_first[CB-1:0];
                            col_last_next   = xl_clamp[CB-1:0];
                            page_next       = req.y_first[3 +: PB];
                            page_first_next = req.y_first[3 +: PB];
                            page_last_next  = yl_clamp[3 +: PB];
                            bit_lo_next     = req.y_first[2:0];
                            bit_hi_next     = yl_clamp[2:0];
                            dot_next        = req.dot_on;
                            if ((req.x_first <= xl_clamp) && (req.y_first <= yl_clamp))
                            begin
                                state_next = ST_RMW_RD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            wipe_addr_next = '0;
                            state_next     = ST_WIPE;
                        end
                        REQ_REFRESH:
                        begin
                            page_next        = PB'(req.page_index);
                            col_next         = '0;
                            byte_idx_next    = '0;
                            first_chunk_next = 1'b1;
                            acc_next         = '0;
                            cmd_next         = CMD_PAGE;
                            if ({2'b00, req.page_index} < PAGE_LIM)
                            begin
                                state_next = ST_CMD;
                            end
                        end
                    endcase
                end
            end

            ST_RMW_RD:
            begin
                state_next = ST_RMW_WR;
            end

            ST_RMW_WR:
            begin
                we         = 1'b1;
                state_next = ST_RMW_RD;
                if (page_reg == page_last_reg)
                begin
                    page_next = page_first_reg;
                    col_next  = col_reg + CB'(1);
                    if (col_reg == col_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    page_next = page_reg + PB'(1);
                end
            end

            ST_CMD:
            begin
                strobe_next                 = 1'b1;
                res_next.control_byte       = CMD_CTRL;
                res_next.byte_count         = 4'd1;
                res_next.transfer_start     = 1'b1;
                res_next.last               = 1'b0;
                unique case (cmd_reg)
                    CMD_PAGE:
                    begin
                        res_next.payload = {56'd0, PAGE_CMD + 8'(page_reg)};
                        cmd_next         = CMD_COL_LO;
                    end
                    CMD_COL_LO:
                    begin
                        res_next.payload = {56'd0, COL_LOW_CMD};
                        cmd_next         = CMD_COL_HI;
                    end
                    default:
                    begin
                        res_next.payload = {56'd0, COL_HIGH_CMD};
                        cmd_next         = CMD_PAGE;
                        state_next       = ST_DAT_RD;
                    end
                endcase
            end

            ST_DAT_RD:
            begin
                state_next = ST_DAT_CAP;
            end

            ST_DAT_CAP:
            begin
                col_next   = col_reg + CB'(1);
                state_next = ST_DAT_RD;
                if ((col_reg == LAST_COL) || (byte_idx_reg == 3'd7))
                begin
                    strobe_next             = 1'b1;
                    res_next.control_byte   = DATA_CTRL;
                    res_next.payload        = acc_word;
                    res_next.byte_count     = {1'b0, byte_idx_reg} + 4'd1;
                    res_next.transfer_start = first_chunk_reg;
                    res_next.last           = (col_reg == LAST_COL);
                    byte_idx_next           = '0;
                    acc_next                = '0;
                    first_chunk_next        = 1'b0;
                    if (col_reg == LAST_COL)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    acc_next      = acc_word;
                    byte_idx_next = byte_idx_reg + 3'd1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_WIPE;
            wipe_addr_reg   <= '0;
            cmd_reg         <= CMD_PAGE;
            strobe_reg      <= 1'b0;
            col_reg         <= '0;
            page_reg        <= '0;
            byte_idx_reg    <= '0;
            first_chunk_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wipe_addr_reg   <= wipe_addr_next;
            cmd_reg         <= cmd_next;
            strobe_reg      <= strobe_next;
            col_reg         <= col_next;
            page_reg        <= page_next;
            byte_idx_reg    <= byte_idx_next;
            first_chunk_reg <= first_chunk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_first_reg  <= col_first_next;
        col_last_reg   <= col_last_next;
        page_first_reg <= page_first_next;
        page_last_reg  <= page_last_next;
        bit_lo_reg     <= bit_lo_next;
        bit_hi_reg     <= bit_hi_next;
        dot_reg        <= dot_next;
        acc_reg        <= acc_next;
        res_reg        <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule
